// ===== rtl/rdd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdd_pkg: shared constants and types of the resource deadlock detector
// Store sizes, field layout of the stream ports, and the control encodings.
// ----------------------------------------------------------------------------
package rdd_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int MAX_RESOURCES = 8;
  localparam int AMOUNT_BITS   = 16;

  localparam int PROC_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RES_W   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int ADDR_W  = PROC_W + RES_W;
  localparam int MAT_DEPTH = 2 ** ADDR_W;
  localparam int PCNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int RCNT_W  = $clog2(MAX_RESOURCES + 1);
  localparam int AVAIL_W = AMOUNT_BITS + PROC_W + 2;

  // Configuration port
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_COUNT = 1'd1;

  // Stream field layout
  localparam int MODE_W   = 2;
  localparam int PIDX_W   = 4;
  localparam int RIDX_W   = 3;
  localparam int AMT_W    = 16;
  localparam int PIDX_LO  = 0;
  localparam int RIDX_LO  = PIDX_LO + PIDX_W;
  localparam int AMT_LO   = RIDX_LO + RIDX_W;
  localparam int S_DATA_W = ((AMT_LO + AMT_W + 7) / 8) * 8;

  localparam int PID_W    = 4;
  localparam int M_DATA_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INST,
    MODE_ALLOC,
    MODE_REQ,
    MODE_DETECT
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_PICK,
    ST_CHECK,
    ST_CWAIT,
    ST_DECIDE,
    ST_RELEASE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SUM,
    OP_CHECK,
    OP_RELEASE
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/resource_deadlock_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// resource_deadlock_detector: multi-instance deadlock detection
// Load items write the instance, allocation and request stores; a detect item
// builds the available vector, sweeps the processes until a pass changes
// nothing, and streams one result per process in use.
// ----------------------------------------------------------------------------
// Load items are written while idle and the input stays ready. A detect item
// holds the input off while it builds the available vector, runs at most P+1
// passes of check and release over the P processes in use and streams the
// results; one read port per store sets the pace.
// Reset clears control, the available vector and finish marks and sets the
// counts to 16 and 8; the instance, allocation and request stores are kept.
// ----------------------------------------------------------------------------
module resource_deadlock_detector (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rdd_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // process_index[3:0], resource_index[6:4], amount[22:7], zero pad
  input  wire logic [rdd_pkg::S_DATA_W-1:0]   s_tdata,
  // mode[1:0]
  input  wire logic [rdd_pkg::MODE_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // process_id[3:0], deadlocked[4], any_deadlock[5], zero pad
  output logic [rdd_pkg::M_DATA_W-1:0]        m_tdata,
  output logic                                m_tlast
);

  localparam int PROC_W  = rdd_pkg::PROC_W;
  localparam int RES_W   = rdd_pkg::RES_W;
  localparam int ADDR_W  = rdd_pkg::ADDR_W;
  localparam int PCNT_W  = rdd_pkg::PCNT_W;
  localparam int RCNT_W  = rdd_pkg::RCNT_W;
  localparam int AVAIL_W = rdd_pkg::AVAIL_W;
  localparam int AMT_B   = rdd_pkg::AMOUNT_BITS;
  localparam int NPROC   = rdd_pkg::MAX_PROCESSES;
  localparam int NRES    = rdd_pkg::MAX_RESOURCES;

  rdd_pkg::state_t state, state_next;
  rdd_pkg::op_t    issue_op, rd_op;
  rdd_pkg::mode_t  in_mode;

  logic [PCNT_W-1:0] pcount;
  logic [RCNT_W-1:0] rcount;
  logic [PROC_W-1:0] pi;
  logic [RES_W-1:0]  rj, rd_j;
  logic              rd_first, issue_first;
  logic              changed, fits;
  logic [NPROC-1:0]  finish;
  logic              pi_last, rj_last;
  logic              in_fire, out_load, any_dead;

  logic [rdd_pkg::PIDX_W-1:0] in_row;
  logic [rdd_pkg::RIDX_W-1:0] in_col;
  logic [rdd_pkg::AMT_W-1:0]  in_amount;
  logic                       row_ok, col_ok;
  logic [ADDR_W-1:0]          wr_addr, rd_addr;

  logic [AMT_B-1:0] inst_mem  [NRES];
  logic [AMT_B-1:0] alloc_mem [rdd_pkg::MAT_DEPTH];
  logic [AMT_B-1:0] req_mem   [rdd_pkg::MAT_DEPTH];
  logic [AMT_B-1:0] inst_q, alloc_q, req_q;

  logic signed [AVAIL_W-1:0] avail [NRES];
  logic signed [AVAIL_W-1:0] inst_ext, alloc_ext, req_ext, sum_base;

  assign in_row    = s_tdata[rdd_pkg::PIDX_LO +: rdd_pkg::PIDX_W];
  assign in_col    = s_tdata[rdd_pkg::RIDX_LO +: rdd_pkg::RIDX_W];
  assign in_amount = s_tdata[rdd_pkg::AMT_LO +: rdd_pkg::AMT_W];
  assign in_mode   = rdd_pkg::mode_t'(s_tuser);
  assign in_fire   = s_tvalid && s_tready;
  assign row_ok    = 32'(in_row) < 32'(NPROC);
  assign col_ok    = 32'(in_col) < 32'(NRES);
  assign wr_addr   = {PROC_W'(in_row), RES_W'(in_col)};
  assign rd_addr   = {pi, rj};

  assign pi_last = (pi == PROC_W'(pcount - 1'b1));
  assign rj_last = (rj == RES_W'(rcount - 1'b1));

  assign inst_ext  = AVAIL_W'(inst_q);
  assign alloc_ext = AVAIL_W'(alloc_q);
  assign req_ext   = AVAIL_W'(req_q);
  assign sum_base  = rd_first ? inst_ext : avail[rd_j];

  always_comb begin
    any_dead = 1'b0;
    for (int k = 0; k < NPROC; k++) begin
      if (!finish[k] && (32'(k) < 32'(pcount))) begin
        any_dead = 1'b1;
      end
    end
  end

  // Store writes and registered reads
  always_ff @(posedge clk) begin
    if (in_fire && col_ok) begin
      case (in_mode)
        rdd_pkg::MODE_INST: inst_mem[RES_W'(in_col)] <= AMT_B'(in_amount);
        rdd_pkg::MODE_ALLOC: begin
          if (row_ok) alloc_mem[wr_addr] <= AMT_B'(in_amount);
        end
        rdd_pkg::MODE_REQ: begin
          if (row_ok) req_mem[wr_addr] <= AMT_B'(in_amount);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    inst_q  <= inst_mem[rj];
    alloc_q <= alloc_mem[rd_addr];
    req_q   <= req_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rdd_pkg::ST_IDLE: begin
        if (in_fire && in_mode == rdd_pkg::MODE_DETECT) state_next = rdd_pkg::ST_SUM;
      end
      rdd_pkg::ST_SUM: begin
        if (pi_last && rj_last) state_next = rdd_pkg::ST_PICK;
      end
      rdd_pkg::ST_PICK: begin
        if (!finish[pi]) state_next = rdd_pkg::ST_CHECK;
        else if (pi_last && !changed) state_next = rdd_pkg::ST_EMIT;
      end
      rdd_pkg::ST_CHECK: begin
        if (rj_last) state_next = rdd_pkg::ST_CWAIT;
      end
      rdd_pkg::ST_CWAIT: state_next = rdd_pkg::ST_DECIDE;
      rdd_pkg::ST_DECIDE: begin
        if (fits) state_next = rdd_pkg::ST_RELEASE;
        else if (pi_last && !changed) state_next = rdd_pkg::ST_EMIT;
        else state_next = rdd_pkg::ST_PICK;
      end
      rdd_pkg::ST_RELEASE: begin
        if (rj_last) state_next = rdd_pkg::ST_PICK;
      end
      rdd_pkg::ST_EMIT: begin
        if (out_load && pi_last) state_next = rdd_pkg::ST_IDLE;
      end
      default: state_next = rdd_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    issue_op    = rdd_pkg::OP_NONE;
    issue_first = (rj == '0);
    s_tready    = 1'b0;
    out_load    = 1'b0;
    case (state)
      rdd_pkg::ST_IDLE: s_tready = 1'b1;
      rdd_pkg::ST_SUM: begin
        issue_op    = rdd_pkg::OP_SUM;
        issue_first = (pi == '0);
      end
      rdd_pkg::ST_CHECK:   issue_op = rdd_pkg::OP_CHECK;
      rdd_pkg::ST_RELEASE: issue_op = rdd_pkg::OP_RELEASE;
      rdd_pkg::ST_EMIT:    out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= PCNT_W'(NPROC);
      rcount <= RCNT_W'(NRES);
    end else if (cfg_we) begin
      case (cfg_index)
        rdd_pkg::REG_PROCESS_COUNT: begin
          if (cfg_data[4:0] == 5'd0) pcount <= PCNT_W'(1);
          else if (32'(cfg_data[4:0]) > 32'(NPROC)) pcount <= PCNT_W'(NPROC);
          else pcount <= PCNT_W'(cfg_data[4:0]);
        end
        rdd_pkg::REG_RESOURCE_COUNT: begin
          if (cfg_data[3:0] == 4'd0) rcount <= RCNT_W'(1);
          else if (32'(cfg_data[3:0]) > 32'(NRES)) rcount <= RCNT_W'(NRES);
          else rcount <= RCNT_W'(cfg_data[3:0]);
        end
        default: ;
      endcase
    end
  end

  // Walk counters, pass flag, finish marks
  always_ff @(posedge clk) begin
    if (rst) begin
      pi      <= '0;
      rj      <= '0;
      changed <= 1'b0;
      finish  <= '0;
    end else begin
      case (state)
        rdd_pkg::ST_IDLE: begin
          if (in_fire && in_mode == rdd_pkg::MODE_DETECT) begin
            pi     <= '0;
            rj     <= '0;
            finish <= '0;
          end
        end
        rdd_pkg::ST_SUM: begin
          if (pi_last) begin
            pi      <= '0;
            rj      <= rj_last ? '0 : rj + 1'b1;
            changed <= 1'b0;
          end else begin
            pi <= pi + 1'b1;
          end
        end
        rdd_pkg::ST_PICK: begin
          rj <= '0;
          if (finish[pi]) begin
            if (pi_last) begin
              pi      <= '0;
              changed <= 1'b0;
            end else begin
              pi <= pi + 1'b1;
            end
          end
        end
        rdd_pkg::ST_CHECK: rj <= rj_last ? '0 : rj + 1'b1;
        rdd_pkg::ST_DECIDE: begin
          rj <= '0;
          if (fits) begin
            finish[pi] <= 1'b1;
            changed    <= 1'b1;
          end else if (pi_last) begin
            pi      <= '0;
            changed <= 1'b0;
          end else begin
            pi <= pi + 1'b1;
          end
        end
        rdd_pkg::ST_RELEASE: begin
          if (rj_last) begin
            rj <= '0;
            if (pi_last) begin
              pi      <= '0;
              changed <= 1'b0;
            end else begin
              pi <= pi + 1'b1;
            end
          end else begin
            rj <= rj + 1'b1;
          end
        end
        rdd_pkg::ST_EMIT: begin
          if (out_load) pi <= pi_last ? '0 : pi + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Read-data stage: apply the returned entry to available or to the fit test
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_op <= rdd_pkg::OP_NONE;
      fits  <= 1'b0;
      for (int k = 0; k < NRES; k++) begin
        avail[k] <= '0;
      end
    end else begin
      rd_op <= issue_op;
      case (rd_op)
        rdd_pkg::OP_SUM:     avail[rd_j] <= sum_base - alloc_ext;
        rdd_pkg::OP_CHECK:   fits <= (rd_first || fits) && !(req_ext > avail[rd_j]);
        rdd_pkg::OP_RELEASE: avail[rd_j] <= avail[rd_j] + alloc_ext;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_j     <= rj;
    rd_first <= issue_first;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, any_dead, !finish[pi], rdd_pkg::PID_W'(pi)};
      m_tlast <= pi_last;
    end
  end

endmodule
`default_nettype wire

// ===== tb/resource_deadlock_detector_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// resource_deadlock_detector_tb: self-checking bench for the deadlock detector
// A queue of load and detect items feeds a stream driver. A built-in predictor
// keeps the stores and counts, runs the release sweeps on each accepted detect
// item, and the monitor checks every result item in order.
// ----------------------------------------------------------------------------
module resource_deadlock_detector_tb;

  localparam int NPROC     = rdd_pkg::MAX_PROCESSES;
  localparam int NRES      = rdd_pkg::MAX_RESOURCES;
  localparam int PIDX_W    = rdd_pkg::PIDX_W;
  localparam int RIDX_W    = rdd_pkg::RIDX_W;
  localparam int AMT_W     = rdd_pkg::AMT_W;
  localparam int PID_W     = rdd_pkg::PID_W;
  localparam int MODE_W    = rdd_pkg::MODE_W;
  localparam int CFG_W     = rdd_pkg::CFG_W;
  localparam int CFG_IDX_W = rdd_pkg::CFG_IDX_W;
  localparam int S_DATA_W  = rdd_pkg::S_DATA_W;
  localparam int M_DATA_W  = rdd_pkg::M_DATA_W;

  typedef struct {
    rdd_pkg::mode_t       mode;
    logic [PIDX_W-1:0]    proc_idx;
    logic [RIDX_W-1:0]    res_idx;
    logic [AMT_W-1:0]     amount;
  } cmd_t;

  typedef struct packed {
    logic                 last;
    logic                 any_dl;
    logic                 dl;
    logic [PID_W-1:0]     pid;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata = '0;
  logic [MODE_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_DATA_W-1:0]    m_tdata;
  logic                   m_tlast;

  cmd_t                   pending_items[$];
  verdict_t               expected_verdicts[$];
  int                     fail_count = 0;
  int                     pushed_count = 0;
  int                     send_idle_pct = 24;
  int                     recv_idle_pct = 66;
  bit                     hold_arm = 1'b0;
  bit                     hold_done;
  int                     hold_left;

  // predictor copy of the stores and counts
  logic [AMT_W-1:0]       inst_amt  [NRES];
  logic [AMT_W-1:0]       alloc_amt [NPROC][NRES];
  logic [AMT_W-1:0]       req_amt   [NPROC][NRES];
  int                     proc_cnt = NPROC;
  int                     res_cnt = NRES;

  // entries already loaded, tracked when items are queued
  bit                     inst_set  [NRES];
  bit                     alloc_set [NPROC][NRES];
  bit                     req_set   [NPROC][NRES];

  resource_deadlock_detector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #2 clk = ~clk;

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic string verdict_str(verdict_t v);
    return $sformatf("pid=%0d dl=%0b any=%0b last=%0b", v.pid, v.dl, v.any_dl, v.last);
  endfunction

  task automatic detect_deadlock();
    longint   avail [NRES];
    bit       done [NPROC];
    bit       progress, fits, any_dl;
    int       i, j;
    verdict_t v;
    for (j = 0; j < res_cnt; j++) begin
      avail[j] = longint'(inst_amt[j]);
      for (i = 0; i < proc_cnt; i++) avail[j] -= longint'(alloc_amt[i][j]);
    end
    for (i = 0; i < NPROC; i++) done[i] = 1'b0;
    progress = 1'b1;
    while (progress) begin
      progress = 1'b0;
      for (i = 0; i < proc_cnt; i++) begin
        if (!done[i]) begin
          fits = 1'b1;
          for (j = 0; j < res_cnt; j++)
            if (longint'(req_amt[i][j]) > avail[j]) fits = 1'b0;
          if (fits) begin
            for (j = 0; j < res_cnt; j++) avail[j] += longint'(alloc_amt[i][j]);
            done[i] = 1'b1;
            progress = 1'b1;
          end
        end
      end
    end
    any_dl = 1'b0;
    for (i = 0; i < proc_cnt; i++) if (!done[i]) any_dl = 1'b1;
    for (i = 0; i < proc_cnt; i++) begin
      v.pid = i[PID_W-1:0];
      v.dl = !done[i];
      v.any_dl = any_dl;
      v.last = (i == proc_cnt - 1);
      expected_verdicts.push_back(v);
    end
  endtask

  task automatic absorb_item(cmd_t c);
    case (c.mode)
      rdd_pkg::MODE_INST:   inst_amt[c.res_idx] = c.amount;
      rdd_pkg::MODE_ALLOC:  alloc_amt[c.proc_idx][c.res_idx] = c.amount;
      rdd_pkg::MODE_REQ:    req_amt[c.proc_idx][c.res_idx] = c.amount;
      rdd_pkg::MODE_DETECT: detect_deadlock();
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tuser <= rdd_pkg::MODE_INST;
    end else begin
      if (s_tvalid && s_tready)
        absorb_item(pending_items.pop_front());
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tuser <= pending_items[0].mode;
          s_tdata <= S_DATA_W'({pending_items[0].amount, pending_items[0].res_idx,
                                pending_items[0].proc_idx});
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off once armed, to back the block up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_arm && !hold_done && m_tvalid) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata[5], m_tdata[4], m_tdata[3:0]};
      if (expected_verdicts.size() == 0) begin
        $display("%0t unexpected item: %s", $time, verdict_str(got));
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected %s, got %s",
                   $time, verdict_str(want), verdict_str(got));
          fail_count++;
        end
      end
    end
  end

  task automatic push_item(rdd_pkg::mode_t m, int p, int r, int a);
    cmd_t c;
    c.mode = m;
    c.proc_idx = p[PIDX_W-1:0];
    c.res_idx = r[RIDX_W-1:0];
    c.amount = AMT_W'(a);
    case (m)
      rdd_pkg::MODE_INST:  inst_set[c.res_idx] = 1'b1;
      rdd_pkg::MODE_ALLOC: alloc_set[c.proc_idx][c.res_idx] = 1'b1;
      rdd_pkg::MODE_REQ:   req_set[c.proc_idx][c.res_idx] = 1'b1;
      default: ;
    endcase
    pending_items.push_back(c);
    pushed_count++;
  endtask

  // load every entry in use that was never written, so a detect reads only known values
  task automatic cover_unwritten();
    int i, j;
    for (j = 0; j < res_cnt; j++)
      if (!inst_set[j])
        push_item(rdd_pkg::MODE_INST, 0, j, int'($urandom_range(3 * proc_cnt)));
    for (i = 0; i < proc_cnt; i++)
      for (j = 0; j < res_cnt; j++) begin
        if (!alloc_set[i][j]) push_item(rdd_pkg::MODE_ALLOC, i, j, int'($urandom_range(2)));
        if (!req_set[i][j]) push_item(rdd_pkg::MODE_REQ, i, j, int'($urandom_range(3)));
      end
  endtask

  function automatic int pick_amount();
    int r;
    r = $urandom_range(99);
    if (r < 60) return int'($urandom_range(3));
    if (r < 75) return int'($urandom_range(12));
    if (r < 90) return int'($urandom_range(65535));
    return r[0] ? 65535 : 0;
  endfunction

  task automatic random_burst(int n);
    int start, k;
    start = pushed_count;
    while (pushed_count - start < n) begin
      if ($urandom_range(99) < 85) begin
        k = $urandom_range(1, 8);
        repeat (k)
          push_item(rdd_pkg::mode_t'($urandom_range(2)), $urandom_range(proc_cnt - 1),
                    $urandom_range(res_cnt - 1), pick_amount());
        cover_unwritten();
        push_item(rdd_pkg::MODE_DETECT, $urandom_range(15), $urandom_range(7),
                  int'($urandom));
      end else if ($urandom_range(1)) begin
        push_item(rdd_pkg::mode_t'($urandom_range(2)), $urandom_range(15),
                  $urandom_range(7), int'($urandom));
      end else begin
        cover_unwritten();
        push_item(rdd_pkg::MODE_DETECT, $urandom_range(15), $urandom_range(7),
                  int'($urandom));
      end
    end
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rdd_pkg::REG_PROCESS_COUNT) proc_cnt = clamp_count(val & 31, NPROC);
    else res_cnt = clamp_count(val & 15, NRES);
  endtask

  task automatic run_phase(int pw, int rw, int n, int s_pct, int r_pct, bit arm);
    settle();
    write_reg(rdd_pkg::REG_PROCESS_COUNT, pw);
    write_reg(rdd_pkg::REG_RESOURCE_COUNT, rw);
    @(negedge clk);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    hold_arm = arm;
    random_burst(n);
  endtask

  initial begin
    foreach (inst_amt[j]) inst_amt[j] = '0;
    foreach (alloc_amt[i, j]) begin
      alloc_amt[i][j] = '0;
      req_amt[i][j] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_reg(rdd_pkg::REG_PROCESS_COUNT, 2);
    write_reg(rdd_pkg::REG_RESOURCE_COUNT, 2);
    @(negedge clk);
    // second process can finish only after the first one releases
    push_item(rdd_pkg::MODE_INST, 0, 0, 3);
    push_item(rdd_pkg::MODE_INST, 0, 1, 65535);
    push_item(rdd_pkg::MODE_ALLOC, 0, 0, 1);
    push_item(rdd_pkg::MODE_ALLOC, 0, 1, 0);
    push_item(rdd_pkg::MODE_ALLOC, 1, 0, 2);
    push_item(rdd_pkg::MODE_ALLOC, 1, 1, 65535);
    push_item(rdd_pkg::MODE_REQ, 0, 0, 0);
    push_item(rdd_pkg::MODE_REQ, 0, 1, 0);
    push_item(rdd_pkg::MODE_REQ, 1, 0, 1);
    push_item(rdd_pkg::MODE_REQ, 1, 1, 0);
    push_item(rdd_pkg::MODE_DETECT, 0, 0, 0);
    // full deadlock
    push_item(rdd_pkg::MODE_REQ, 0, 0, 2);
    push_item(rdd_pkg::MODE_DETECT, 15, 7, 65535);
    // only the second process stuck
    push_item(rdd_pkg::MODE_REQ, 0, 0, 0);
    push_item(rdd_pkg::MODE_REQ, 1, 0, 2);
    push_item(rdd_pkg::MODE_DETECT, 0, 0, 0);
    // over-allocated resource: available goes negative, zero requests still fail
    push_item(rdd_pkg::MODE_INST, 0, 1, 0);
    push_item(rdd_pkg::MODE_REQ, 1, 0, 0);
    push_item(rdd_pkg::MODE_DETECT, 0, 0, 0);
    // loads outside the counts in use are stored but not read
    push_item(rdd_pkg::MODE_ALLOC, 15, 7, 65535);
    push_item(rdd_pkg::MODE_REQ, 15, 7, 65535);
    push_item(rdd_pkg::MODE_INST, 0, 7, 65535);
    push_item(rdd_pkg::MODE_INST, 0, 1, 65535);
    push_item(rdd_pkg::MODE_DETECT, 0, 0, 0);

    run_phase(0, 0, 20, 24, 66, 1'b0);
    run_phase(31, 2, 40, 24, 66, 1'b0);
    run_phase(5, 3, 50, 66, 24, 1'b1);
    run_phase(3, 31, 40, 66, 24, 1'b0);
    run_phase(17, 3, 30, 0, 0, 1'b0);
    run_phase($urandom_range(1, 16), $urandom_range(1, 3), 40, 0, 0, 1'b0);
    run_phase(1, 8, 30, 0, 0, 1'b0);
    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== resource_deadlock_detector.f =====
rtl/rdd_pkg.sv
rtl/resource_deadlock_detector.sv
tb/resource_deadlock_detector_tb.sv
